// File: src/cpt_pkg.sv
// ----------------------------------------------------------------------------
// Convex polygon point test package
// Shared constants, codes and types for the polygon store and edge walk.
// ----------------------------------------------------------------------------
package cpt_pkg;

   localparam int MAX_VERTICES_DEF = 8;
   localparam int COORD_WIDTH_DEF  = 16;
   localparam int FIELD_W          = 16;
   localparam int KIND_W           = 2;
   localparam int MIN_VERTICES     = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_TEST   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_WALK,
      ST_WRAP,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Outcome of one edge, formed combinationally from the registered products.
   typedef struct packed {
      logic valid;
      logic first;
      logic skip;
      logic above;
   } edge_res_type;

endpackage

// File: src/cpt_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module cpt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/cpt_edge_unit.sv
// ----------------------------------------------------------------------------
// Edge cross product unit
// Forms the edge deltas and both cross product terms, registers them, and
// reports whether the point lies strictly to the left of the edge.
// ----------------------------------------------------------------------------
module cpt_edge_unit #(
   parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          edge_valid,
   input  logic                          edge_first,
   input  logic signed [COORD_WIDTH-1:0] xi,
   input  logic signed [COORD_WIDTH-1:0] yi,
   input  logic signed [COORD_WIDTH-1:0] xj,
   input  logic signed [COORD_WIDTH-1:0] yj,
   input  logic signed [COORD_WIDTH-1:0] px,
   input  logic signed [COORD_WIDTH-1:0] py,
   output cpt_pkg::edge_res_type         res
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;

   logic signed [DW-1:0] dx;
   logic signed [DW-1:0] dy;
   logic signed [DW-1:0] rx;
   logic signed [DW-1:0] ry;
   logic signed [PW-1:0] lhs_in;
   logic signed [PW-1:0] rhs_in;
   logic signed [PW-1:0] lhs_ff;
   logic signed [PW-1:0] rhs_ff;
   logic                 skip_ff;
   logic                 first_ff;
   logic                 valid_ff;

   always_comb begin
      dx     = DW'(xj) - DW'(xi);
      dy     = DW'(yj) - DW'(yi);
      rx     = DW'(px) - DW'(xi);
      ry     = DW'(py) - DW'(yi);
      lhs_in = PW'(ry) * PW'(dx);
      rhs_in = PW'(rx) * PW'(dy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= edge_valid;
      end
      lhs_ff   <= lhs_in;
      rhs_ff   <= rhs_in;
      skip_ff  <= (dx == '0) && (dy == '0);
      first_ff <= edge_first;
   end

   always_comb begin
      res.valid = valid_ff;
      res.first = first_ff;
      res.skip  = skip_ff;
      res.above = lhs_ff > rhs_ff;
   end

endmodule

// File: src/convex_polygon_point_test_top.sv
// ----------------------------------------------------------------------------
// Convex polygon point test
// Stores a polygon in a vertex RAM and tests query points against it by
// walking every edge through a registered cross product unit.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  req_kind, req_point_x, req_point_y
//   rsp      out        rsp_valid / rsp_ready  rsp_inside_res
//
// Clear and append transactions complete in the cycle they are accepted.
// A test with three or more stored vertices reads one vertex per cycle from the
// RAM into the edge pipeline registers, closes with the edge back to vertex 0,
// waits in a drain check, and then loads the output register and raises
// rsp_valid, returning to idle at the same time. With fewer than three vertices
// the test goes straight to that final step and answers outside.
// One transaction is in flight; a finished test waits while the output register
// is full, and req_ready stays low meanwhile.
// Reset empties the polygon and drops any pending response; the RAM contents
// are not cleared, since no entry at or above the vertex count is ever used.
// ----------------------------------------------------------------------------
module convex_polygon_point_test_top #(
   parameter int MAX_VERTICES = cpt_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = cpt_pkg::COORD_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [cpt_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [cpt_pkg::FIELD_W-1:0] req_point_x,
   input  logic signed [cpt_pkg::FIELD_W-1:0] req_point_y,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_inside_res
);

   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int ADDR_W = $clog2(MAX_VERTICES);
   localparam int RAM_W  = 2 * COORD_WIDTH;

   cpt_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [CNT_W-1:0]              rd_ptr_ff, rd_ptr_in;
   logic                          last_ff, last_in;
   logic signed [COORD_WIDTH-1:0] px_ff, px_in;
   logic signed [COORD_WIDTH-1:0] py_ff, py_in;
   logic signed [COORD_WIDTH-1:0] v0x_ff, v0x_in;
   logic signed [COORD_WIDTH-1:0] v0y_ff, v0y_in;
   logic signed [COORD_WIDTH-1:0] curx_ff, curx_in;
   logic signed [COORD_WIDTH-1:0] cury_ff, cury_in;
   logic signed [COORD_WIDTH-1:0] exi_ff, exi_in;
   logic signed [COORD_WIDTH-1:0] eyi_ff, eyi_in;
   logic signed [COORD_WIDTH-1:0] exj_ff, exj_in;
   logic signed [COORD_WIDTH-1:0] eyj_ff, eyj_in;
   logic                          e_valid_ff, e_valid_in;
   logic                          e_first_ff, e_first_in;
   logic                          edge0_ff, edge0_in;
   logic                          ref_ff, ref_in;
   logic                          ok_ff, ok_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_inside_ff, rsp_inside_in;

   logic                          req_fire;
   logic                          ram_wr_en;
   logic [ADDR_W-1:0]             ram_wr_addr;
   logic [ADDR_W-1:0]             ram_rd_addr;
   logic [RAM_W-1:0]              ram_rd_data;
   logic signed [COORD_WIDTH-1:0] req_x;
   logic signed [COORD_WIDTH-1:0] req_y;
   logic signed [COORD_WIDTH-1:0] ram_x;
   logic signed [COORD_WIDTH-1:0] ram_y;
   cpt_pkg::edge_res_type         edge_res;

   // The query coordinates keep their low COORD_WIDTH bits, sign extended
   // when the internal width is larger than the port.
   assign req_x = COORD_WIDTH'(req_point_x);
   assign req_y = COORD_WIDTH'(req_point_y);
   assign ram_x = ram_rd_data[COORD_WIDTH-1:0];
   assign ram_y = ram_rd_data[RAM_W-1:COORD_WIDTH];

   assign req_ready      = (state_ff == cpt_pkg::ST_IDLE);
   assign req_fire       = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign ram_wr_addr    = cnt_ff[ADDR_W-1:0];

   // Vertex store: y in the upper half of each word, x in the lower half.
   cpt_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({req_y, req_x}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cpt_edge_unit #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_edge_unit (
      .clock      (clock),
      .reset      (reset),
      .edge_valid (e_valid_ff),
      .edge_first (e_first_ff),
      .xi         (exi_ff),
      .yi         (eyi_ff),
      .xj         (exj_ff),
      .yj         (eyj_ff),
      .px         (px_ff),
      .py         (py_ff),
      .res        (edge_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpt_pkg::ST_IDLE;
         cnt_ff       <= '0;
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         e_valid_ff   <= e_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ptr_ff     <= rd_ptr_in;
      last_ff       <= last_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      v0x_ff        <= v0x_in;
      v0y_ff        <= v0y_in;
      curx_ff       <= curx_in;
      cury_ff       <= cury_in;
      exi_ff        <= exi_in;
      eyi_ff        <= eyi_in;
      exj_ff        <= exj_in;
      eyj_ff        <= eyj_in;
      e_first_ff    <= e_first_in;
      edge0_ff      <= edge0_in;
      ref_ff        <= ref_in;
      ok_ff         <= ok_in;
      rsp_inside_ff <= rsp_inside_in;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rd_ptr_in     = rd_ptr_ff;
      last_in       = last_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      v0x_in        = v0x_ff;
      v0y_in        = v0y_ff;
      curx_in       = curx_ff;
      cury_in       = cury_ff;
      exi_in        = exi_ff;
      eyi_in        = eyi_ff;
      exj_in        = exj_ff;
      eyj_in        = eyj_ff;
      e_valid_in    = 1'b0;
      e_first_in    = e_first_ff;
      edge0_in      = edge0_ff;
      ref_in        = ref_ff;
      ok_in         = ok_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_inside_in = rsp_inside_ff;
      ram_wr_en     = 1'b0;
      ram_rd_addr   = rd_ptr_ff[ADDR_W-1:0];

      // A taken response frees the output register.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Fold each finished edge into the verdict. Edge 0 sets the reference
      // direction; a skipped edge 0 leaves the reference at zero.
      if (edge_res.valid && !edge_res.skip) begin
         if (edge_res.first) begin
            ref_in = edge_res.above;
         end else if (edge_res.above != ref_ff) begin
            ok_in = 1'b0;
         end
      end

      case (state_ff)
         cpt_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_kind)
                  cpt_pkg::KIND_CLEAR: begin
                     cnt_in = '0;
                  end
                  cpt_pkg::KIND_APPEND: begin
                     if (cnt_ff < CNT_W'(MAX_VERTICES)) begin
                        ram_wr_en = 1'b1;
                        cnt_in    = cnt_ff + CNT_W'(1);
                     end
                  end
                  cpt_pkg::KIND_TEST: begin
                     px_in    = req_x;
                     py_in    = req_y;
                     ref_in   = 1'b0;
                     edge0_in = 1'b1;
                     if (cnt_ff < CNT_W'(cpt_pkg::MIN_VERTICES)) begin
                        ok_in    = 1'b0;
                        state_in = cpt_pkg::ST_DONE;
                     end else begin
                        ok_in       = 1'b1;
                        ram_rd_addr = '0;
                        rd_ptr_in   = CNT_W'(1);
                        last_in     = 1'b0;
                        state_in    = cpt_pkg::ST_LOAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         cpt_pkg::ST_LOAD: begin
            // Vertex 0 arrives; keep it for the closing edge.
            v0x_in    = ram_x;
            v0y_in    = ram_y;
            curx_in   = ram_x;
            cury_in   = ram_y;
            last_in   = (rd_ptr_ff == cnt_ff - CNT_W'(1));
            rd_ptr_in = rd_ptr_ff + CNT_W'(1);
            state_in  = cpt_pkg::ST_WALK;
         end
         cpt_pkg::ST_WALK: begin
            e_valid_in = 1'b1;
            e_first_in = edge0_ff;
            edge0_in   = 1'b0;
            exi_in     = curx_ff;
            eyi_in     = cury_ff;
            exj_in     = ram_x;
            eyj_in     = ram_y;
            curx_in    = ram_x;
            cury_in    = ram_y;
            if (last_ff) begin
               state_in = cpt_pkg::ST_WRAP;
            end else begin
               last_in   = (rd_ptr_ff == cnt_ff - CNT_W'(1));
               rd_ptr_in = rd_ptr_ff + CNT_W'(1);
            end
         end
         cpt_pkg::ST_WRAP: begin
            // Closing edge from the last vertex back to vertex 0.
            e_valid_in = 1'b1;
            e_first_in = 1'b0;
            exi_in     = curx_ff;
            eyi_in     = cury_ff;
            exj_in     = v0x_ff;
            eyj_in     = v0y_ff;
            state_in   = cpt_pkg::ST_DRAIN;
         end
         cpt_pkg::ST_DRAIN: begin
            if (!e_valid_ff && !edge_res.valid) begin
               state_in = cpt_pkg::ST_DONE;
            end
         end
         cpt_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = ok_ff;
               state_in      = cpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cpt_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // The vertex count never passes the polygon capacity.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_VERTICES))
      else $error("vertex count exceeds capacity");

   // A new response is only produced by the final step of a test.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == cpt_pkg::ST_DONE))
      else $error("response raised outside the final step");

   // While idle, no edge is left in the cross product pipeline.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == cpt_pkg::ST_IDLE) |-> (!e_valid_ff && !edge_res.valid))
      else $error("edge pipeline busy while idle");

   // The vertex RAM is written only by an accepted append.
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (req_fire && (req_kind == cpt_pkg::KIND_APPEND)))
      else $error("vertex RAM written outside an append");

   // The closing edge is formed only after the last vertex was seen.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == cpt_pkg::ST_WRAP) |-> $past(state_ff == cpt_pkg::ST_WALK && last_ff))
      else $error("closing edge formed before the last vertex");
`endif

endmodule

// File: dv/convex_polygon_point_test_top_tb.sv
// ----------------------------------------------------------------------------
// Convex polygon point test testbench
// Sends clear, append and test transactions to the polygon block, predicts each
// test answer not typed in with an exact integer cross product walk, and checks
// each response in order under random idling and backpressure on both channels.
// ----------------------------------------------------------------------------
module convex_polygon_point_test_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [cpt_pkg::KIND_W-1:0]         kind_bits_type;
   typedef logic signed [cpt_pkg::FIELD_W-1:0] coord_type;

   typedef struct packed {
      kind_bits_type kind;
      coord_type     x;
      coord_type     y;
      int            want;
   } dir_row_type;

   // The block ignores the one kind code that the package leaves unnamed.
   localparam kind_bits_type KIND_IGNORED = 2'd3;
   localparam int MAX_V       = cpt_pkg::MAX_VERTICES_DEF;
   localparam int TOTAL_ITEMS = 1700;
   localparam int HOLD_AT     = 500;
   localparam int DRAIN_AT    = 1000;
   localparam int QUIET_LAST  = 200;
   localparam int HOLD_CYCLES = 300;
   // A directed row with this value is checked against the predictor.
   localparam int FROM_MODEL  = -1;

   logic                clock;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   kind_bits_type       req_kind       = '0;
   coord_type           req_point_x    = '0;
   coord_type           req_point_y    = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic                rsp_inside_res;

   // The testbench's own copy of the stored polygon.
   coord_type           poly_x [MAX_V];
   coord_type           poly_y [MAX_V];
   int                  poly_count     = 0;

   // Answers still owed by the block, oldest first, with the test numbers.
   bit                  expected_inside_q [$];
   int                  expected_test_no_q [$];

   int                  items_sent     = 0;
   int                  tests_sent     = 0;
   int                  mismatch_count = 0;
   bit                  quiet_phase    = 1'b0;
   bit                  rsp_hold_req   = 1'b0;

   convex_polygon_point_test_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_inside_res (rsp_inside_res)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs on either channel.
   initial begin
      #1_000_000;
      $display("timeout: %0d test answers still outstanding", expected_inside_q.size());
      $display("convex_polygon_point_test_top_tb: FAIL");
      $finish;
   end

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("MISMATCH at %0t ns: %s", $time, what);
      end
   endtask

   function automatic int rand_int(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic int clamp_coord(int v);
      if (v < -32768) return -32768;
      if (v > 32767) return 32767;
      return v;
   endfunction

   // Walks every edge of the stored polygon. The differences are one bit
   // wider than a coordinate and the products twice that, so the sign test
   // of the cross product is exact. A zero-length edge is skipped, and if
   // edge 0 is skipped the reference direction stays "not above".
   function automatic bit polygon_contains(coord_type px, coord_type py);
      logic signed [cpt_pkg::FIELD_W:0]     dx, dy, rel_x, rel_y;
      logic signed [2*cpt_pkg::FIELD_W+1:0] lhs, rhs;
      bit ref_above, above;
      int i, j;
      if (poly_count < cpt_pkg::MIN_VERTICES) return 1'b0;
      ref_above = 1'b0;
      for (i = 0; i < poly_count; i++) begin
         j = (i + 1 == poly_count) ? 0 : i + 1;
         dx = poly_x[j] - poly_x[i];
         dy = poly_y[j] - poly_y[i];
         if (dx == 0 && dy == 0) continue;
         rel_x = px - poly_x[i];
         rel_y = py - poly_y[i];
         lhs = rel_y * dx;
         rhs = rel_x * dy;
         above = (lhs > rhs);
         if (i == 0) ref_above = above;
         if (above != ref_above) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Applies one accepted transaction to the polygon copy. Only a test
   // produces an answer; an append to a full polygon is dropped.
   task automatic apply_transaction(input kind_bits_type kind, input coord_type x,
                                    input coord_type y, output bit produces,
                                    output bit answer);
      produces = 1'b0;
      answer   = 1'b0;
      if (kind == cpt_pkg::KIND_CLEAR) begin
         poly_count = 0;
      end else if (kind == cpt_pkg::KIND_APPEND) begin
         if (poly_count < MAX_V) begin
            poly_x[poly_count] = x;
            poly_y[poly_count] = y;
            poly_count++;
         end
      end else if (kind == cpt_pkg::KIND_TEST) begin
         produces = 1'b1;
         answer   = polygon_contains(x, y);
      end
   endtask

   // Offers one transaction from a falling edge and returns at the falling
   // edge after it was taken. Outside the quiet phase the sender sometimes
   // drops valid for a short burst first and wiggles the idle payload.
   task automatic send_item(input kind_bits_type kind, input int x, input int y,
                            input int want);
      bit produces, answer;
      int gap;
      coord_type cx, cy;
      cx = coord_type'(x);
      cy = coord_type'(y);
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) begin
            req_kind    <= kind_bits_type'($urandom_range(0, 3));
            req_point_x <= coord_type'($urandom_range(0, 65535));
            req_point_y <= coord_type'($urandom_range(0, 65535));
            @(negedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_point_x <= cx;
      req_point_y <= cy;
      do @(posedge clock); while (!req_ready);
      if (kind != KIND_IGNORED) items_sent++;
      apply_transaction(kind, cx, cy, produces, answer);
      if (produces) begin
         expected_inside_q.push_back((want == FROM_MODEL) ? answer : want[0]);
         expected_test_no_q.push_back(tests_sent);
         tests_sent++;
      end
      @(negedge clock);
   endtask

   // Builds one polygon, loads it and fires test points at it. Most shapes
   // are convex (an octagon with cut corners, reduced to a random subset of
   // its corners, a triangle, a rectangle reaching the coordinate extremes);
   // the rest are arbitrary point sets, often packed into a tiny window so
   // that duplicates and collinear vertices turn up. Order, start vertex and
   // a doubled vertex are randomized so that every edge, edge 0 included,
   // can be of zero length.
   task automatic run_polygon_sequence(int n_tests);
      int fx [8];
      int fy [8];
      int qx [$];
      int qy [$];
      int shape, n, cx, cy, a, b, c, k, nxt, r, t, mx, my, tx, ty, span;
      shape = $urandom_range(0, 9);
      if (shape <= 4) begin
         cx = rand_int(-16000, 16000);
         cy = rand_int(-16000, 16000);
         a  = rand_int(1, 16000);
         b  = rand_int(1, 16000);
         c  = rand_int(0, (a < b) ? a : b);
         fx = '{cx-a+c, cx+a-c, cx+a, cx+a, cx+a-c, cx-a+c, cx-a, cx-a};
         fy = '{cy-b, cy-b, cy-b+c, cy+b-c, cy+b, cy+b, cy+b-c, cy-b+c};
         for (k = 0; k < 8; k++) begin
            qx.push_back(fx[k]);
            qy.push_back(fy[k]);
         end
         n = $urandom_range(3, 8);
         while (qx.size() > n) begin
            k = $urandom_range(0, qx.size() - 1);
            qx.delete(k);
            qy.delete(k);
         end
      end else if (shape <= 6) begin
         repeat (3) begin
            qx.push_back(rand_int(-32768, 32767));
            qy.push_back(rand_int(-32768, 32767));
         end
      end else if (shape == 7) begin
         a = $urandom_range(0, 1) ? -32768 : rand_int(-32768, 0);
         b = $urandom_range(0, 1) ? 32767 : rand_int(1, 32767);
         c = $urandom_range(0, 1) ? -32768 : rand_int(-32768, 0);
         t = $urandom_range(0, 1) ? 32767 : rand_int(1, 32767);
         qx = '{a, b, b, a};
         qy = '{c, c, t, t};
      end else begin
         n    = $urandom_range(3, 8);
         span = $urandom_range(0, 1) ? 63 : 32767;
         repeat (n) begin
            qx.push_back(rand_int(-span - 1, span));
            qy.push_back(rand_int(-span - 1, span));
         end
      end

      r = $urandom_range(0, qx.size() - 1);
      repeat (r) begin
         qx.push_back(qx.pop_front());
         qy.push_back(qy.pop_front());
      end
      // Half the polygons run clockwise.
      if ($urandom_range(0, 1)) begin
         for (k = 0; k < qx.size() / 2; k++) begin
            t = qx[k]; qx[k] = qx[qx.size()-1-k]; qx[qx.size()-1-k] = t;
            t = qy[k]; qy[k] = qy[qy.size()-1-k]; qy[qy.size()-1-k] = t;
         end
      end
      if (qx.size() < MAX_V && $urandom_range(0, 5) == 0) begin
         k = $urandom_range(0, qx.size() - 1);
         qx.insert(k, qx[k]);
         qy.insert(k, qy[k]);
      end

      // Now and then the clear is left out, so the new vertices land on top
      // of whatever is stored.
      if ($urandom_range(0, 7) != 0) begin
         send_item(cpt_pkg::KIND_CLEAR, rand_int(-32768, 32767), rand_int(-32768, 32767),
                   FROM_MODEL);
      end
      for (k = 0; k < qx.size(); k++) begin
         send_item(cpt_pkg::KIND_APPEND, qx[k], qy[k], FROM_MODEL);
      end
      // Occasional extra appends, dropped once the polygon is full.
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 2)) begin
            send_item(cpt_pkg::KIND_APPEND, rand_int(-32768, 32767),
                      rand_int(-32768, 32767), FROM_MODEL);
         end
      end

      mx = 0;
      my = 0;
      for (k = 0; k < qx.size(); k++) begin
         mx += qx[k];
         my += qy[k];
      end
      mx = mx / qx.size();
      my = my / qy.size();
      repeat (n_tests) begin
         k   = $urandom_range(0, qx.size() - 1);
         nxt = (k + 1) % qx.size();
         case ($urandom_range(0, 5))
            0: begin tx = mx; ty = my; end
            1: begin tx = qx[k]; ty = qy[k]; end
            2: begin tx = (qx[k] + qx[nxt]) / 2; ty = (qy[k] + qy[nxt]) / 2; end
            3: begin tx = mx + rand_int(-256, 256); ty = my + rand_int(-256, 256); end
            4: begin tx = rand_int(-32768, 32767); ty = rand_int(-32768, 32767); end
            default: begin tx = qx[k] + rand_int(-2, 2); ty = qy[k] + rand_int(-2, 2); end
         endcase
         send_item(cpt_pkg::KIND_TEST, clamp_coord(tx), clamp_coord(ty), FROM_MODEL);
      end
   endtask

   function automatic dir_row_type dir_row(int kind, int x, int y, int want);
      dir_row_type row;
      row.kind = kind_bits_type'(kind);
      row.x    = coord_type'(x);
      row.y    = coord_type'(y);
      row.want = want;
      return row;
   endfunction

   // Response side. Ready drops in short random bursts, and once during the
   // run the sender asks for a long hold-off, which this process counts out
   // on its own while the sender keeps offering tests. In the quiet phase
   // at the end ready stays high.
   initial begin : rsp_side
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(1, 5) - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Every response taken at a rising edge is compared with the oldest
   // answer still owed.
   always @(posedge clock) begin : rsp_check
      bit want_inside;
      int test_no;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_inside_q.size() == 0) begin
            report_mismatch($sformatf("response %0b with no test outstanding",
                                      rsp_inside_res));
         end else begin
            want_inside = expected_inside_q.pop_front();
            test_no     = expected_test_no_q.pop_front();
            if (rsp_inside_res !== want_inside) begin
               report_mismatch($sformatf("test %0d: inside_res %b, expected %0b",
                                         test_no, rsp_inside_res, want_inside));
            end
         end
      end
   end

   initial begin : stimulus
      dir_row_type rows [$];
      bit hold_done, drain_done;
      int k;
      hold_done  = 1'b0;
      drain_done = 1'b0;

      // Directed part. Answers are typed in where they are obvious: too few
      // vertices, an empty polygon after a clear, and the center of the
      // full-range square, which every edge sees on its left.
      rows.push_back(dir_row(cpt_pkg::KIND_TEST,   0, 0, 0));
      rows.push_back(dir_row(cpt_pkg::KIND_APPEND, -32768, -32768, FROM_MODEL));
      rows.push_back(dir_row(cpt_pkg::KIND_TEST,   0, 0, 0));
      rows.push_back(dir_row(cpt_pkg::KIND_APPEND, 32767, -32768, FROM_MODEL));
      rows.push_back(dir_row(cpt_pkg::KIND_TEST,   0, 0, 0));
      rows.push_back(dir_row(cpt_pkg::KIND_APPEND, 32767, 32767, FROM_MODEL));
      rows.push_back(dir_row(cpt_pkg::KIND_APPEND, -32768, 32767, FROM_MODEL));
      rows.push_back(dir_row(cpt_pkg::KIND_TEST,   0, 0, 1));
      rows.push_back(dir_row(cpt_pkg::KIND_TEST,   -32768, -32768, FROM_MODEL));
      rows.push_back(dir_row(cpt_pkg::KIND_TEST,   32767, 32767, FROM_MODEL));
      rows.push_back(dir_row(cpt_pkg::KIND_TEST,   -32768, 32767, FROM_MODEL));
      rows.push_back(dir_row(KIND_IGNORED, -1, -1, FROM_MODEL));
      // Repeating the last corner fills the store with zero-length edges.
      rows.push_back(dir_row(cpt_pkg::KIND_APPEND, -32768, 32767, FROM_MODEL));
      rows.push_back(dir_row(cpt_pkg::KIND_APPEND, -32768, 32767, FROM_MODEL));
      rows.push_back(dir_row(cpt_pkg::KIND_APPEND, -32768, 32767, FROM_MODEL));
      rows.push_back(dir_row(cpt_pkg::KIND_APPEND, -32768, 32767, FROM_MODEL));
      // The polygon is full, so this vertex must be dropped.
      rows.push_back(dir_row(cpt_pkg::KIND_APPEND, 0, 0, FROM_MODEL));
      rows.push_back(dir_row(cpt_pkg::KIND_TEST,   0, 0, FROM_MODEL));
      rows.push_back(dir_row(cpt_pkg::KIND_CLEAR,  -1, -1, FROM_MODEL));
      rows.push_back(dir_row(cpt_pkg::KIND_TEST,   0, 0, 0));
      // Edge 0 of zero length leaves the reference direction at "not above".
      rows.push_back(dir_row(cpt_pkg::KIND_APPEND, 100, 100, FROM_MODEL));
      rows.push_back(dir_row(cpt_pkg::KIND_APPEND, 100, 100, FROM_MODEL));
      rows.push_back(dir_row(cpt_pkg::KIND_APPEND, 200, 100, FROM_MODEL));
      rows.push_back(dir_row(cpt_pkg::KIND_APPEND, 100, 200, FROM_MODEL));
      rows.push_back(dir_row(cpt_pkg::KIND_TEST,   120, 120, FROM_MODEL));
      rows.push_back(dir_row(cpt_pkg::KIND_CLEAR,  0, 0, FROM_MODEL));

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      for (k = 0; k < rows.size(); k++) begin
         send_item(rows[k].kind, int'(rows[k].x), int'(rows[k].y), rows[k].want);
      end

      // Random part: mostly well-formed polygon sequences, with bursts of
      // arbitrary transactions mixed in between.
      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent >= TOTAL_ITEMS - QUIET_LAST) quiet_phase = 1'b1;
         if (!drain_done && items_sent >= DRAIN_AT) begin
            // The sender stands still until every owed answer has come back.
            drain_done = 1'b1;
            req_valid <= 1'b0;
            @(negedge clock);
            while (expected_inside_q.size() != 0) @(negedge clock);
         end
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               send_item(kind_bits_type'($urandom_range(0, 3)), rand_int(-32768, 32767),
                         rand_int(-32768, 32767), FROM_MODEL);
            end
         end
         if (!hold_done && items_sent >= HOLD_AT) begin
            // Long response hold-off with a test-heavy sequence behind it, so
            // the block backs up into its request channel.
            hold_done    = 1'b1;
            rsp_hold_req = 1'b1;
            run_polygon_sequence(20);
         end else begin
            run_polygon_sequence($urandom_range(2, 10));
         end
      end

      req_valid <= 1'b0;
      while (expected_inside_q.size() != 0) @(negedge clock);
      // Room for a stray extra response to show up.
      repeat (32) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("convex_polygon_point_test_top_tb: PASS");
      end else begin
         $display("convex_polygon_point_test_top_tb: FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/cpt_pkg.sv
src/cpt_ram.sv
src/cpt_edge_unit.sv
src/convex_polygon_point_test_top.sv
dv/convex_polygon_point_test_top_tb.sv
